// ----- rtl/qbje_pkg.sv -----
// ----------------------------------------------------------------------------
// qbje_pkg
// shared types, constants and arithmetic helpers of the quintic bezier
// joint evaluator
// ----------------------------------------------------------------------------
package qbje_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic [16:0]        t_frac;

    typedef enum logic [0:0] {
        REG_DURATION     = 1'b0,
        REG_INV_DURATION = 1'b1
    } t_reg_idx;

    localparam t_frac       Q16_ONE     = 17'd65536;
    localparam logic [31:0] CFG_RESET   = 32'd65536;
    localparam t_q16        Q16_ONE_S   = 32'sd65536;
    localparam int          LANES       = 2;
    localparam int          DEG         = 5;
    localparam int          N_CP        = DEG + 1;
    localparam int          DIG_BITS    = 17;
    localparam int          DIV_STEPS   = 3;
    localparam int          DIV_BITS    = DIG_BITS * DIV_STEPS;
    localparam int          DIV_OFS_EXP = 48;
    localparam logic [19:0] DIV5_MUL    = 20'd838861;
    localparam int          PIPE_LAT    = 23;

    // bias that makes every dividend positive, a multiple of five
    localparam logic signed [64:0] DIV_BIAS = 65'sd5 <<< DIV_OFS_EXP;
    localparam logic signed [52:0] QUO_OFS  = 53'sd1 <<< DIV_OFS_EXP;

    function automatic t_q16 sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
        if (x > 64'sd549755813887) begin
            return 40'sh7fffffffff;
        end else if (x < -64'sd549755813888) begin
            return 40'sh8000000000;
        end
        return x[39:0];
    endfunction

    // h + round-half-up(l / 2^16)
    function automatic logic signed [63:0] add_rnd16(input logic signed [63:0] h,
                                                     input logic signed [63:0] l);
        return h + ((l + 64'sd32768) >>> 16);
    endfunction

    // quotient of a value below 5 * 2^17 by five
    function automatic logic [16:0] div5_quo(input logic [19:0] v);
        logic [39:0] p;
        p = v * DIV5_MUL;
        return p[38:22];
    endfunction

    function automatic logic [2:0] div5_rem(input logic [19:0] v, input logic [16:0] q);
        logic [19:0] m;
        logic [19:0] r;
        m = {1'b0, q, 2'b00} + {3'b000, q};
        r = v - m;
        return r[2:0];
    endfunction

endpackage

// ----- rtl/quintic_bezier_joint_eval.sv -----
// ----------------------------------------------------------------------------
// quintic_bezier_joint_eval
// degree-5 bezier trajectory of one joint at one normalized time: position,
// velocity, acceleration and their sensitivities to the goal position
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//  sample in | start, busy         | i_time_frac, i_start_*, i_goal_pos
//  result    | o_done (strobe)     | o_pos, o_vel, o_acc, o_*_sens
//
//  one transfer per cycle; the delay from start to o_done is set by the chain
//  of multipliers (control points, five casteljau levels, two 1/T scalings)
//  busy stays low, the pipeline never stalls and o_done is never held off
//  synchronous reset clears the valid bits and sets both registers to 1.0
// ----------------------------------------------------------------------------
module quintic_bezier_joint_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  qbje_pkg::t_reg_idx i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              start,
    output logic              busy,
    input  qbje_pkg::t_frac   i_time_frac,
    input  qbje_pkg::t_q16    i_start_pos,
    input  qbje_pkg::t_q16    i_start_vel,
    input  qbje_pkg::t_q16    i_start_acc,
    input  qbje_pkg::t_q16    i_goal_pos,
    output logic              o_done,
    output qbje_pkg::t_q16    o_pos,
    output qbje_pkg::t_q16    o_vel,
    output qbje_pkg::t_q16    o_acc,
    output qbje_pkg::t_frac   o_pos_sens,
    output qbje_pkg::t_q16    o_vel_sens,
    output qbje_pkg::t_q16    o_acc_sens
);
    import qbje_pkg::*;

    logic [31:0]           r_duration;
    logic [31:0]           r_inv_duration;
    logic [PIPE_LAT-1:0]   r_vld;
    logic                  w_acc;

    // front end
    t_frac                 r1_t, r2_t, r3_t, r4_t, r5_t;
    t_q16                  r1_q0, r2_q0, r3_q0, r4_q0, r5_q0;
    t_q16                  r1_g, r2_g, r3_g, r4_g, r5_g;
    t_q16                  r1_v0;
    t_q16                  r1_a0, r2_a0, r3_a0;
    logic signed [63:0]    r2_tv, r3_tv, r4_tv;
    logic [63:0]           r2_dd;
    logic [31:0]           r3_tsq;
    logic signed [63:0]    r4_tt;
    logic [64:0]           w_dd_rnd;
    logic signed [64:0]    w_u [3];
    logic [DIV_BITS-1:0]   r5_u [3];

    // divide by five, one 17-bit digit a stage
    logic [DIV_BITS-1:0]   r_dn [DIV_STEPS][3];
    logic [DIV_BITS-1:0]   r_dq [DIV_STEPS][3];
    logic [2:0]            r_dr [DIV_STEPS][3];
    t_frac                 r_dt [DIV_STEPS];
    t_q16                  r_dq0 [DIV_STEPS];
    t_q16                  r_dg [DIV_STEPS];
    logic [DIV_BITS-1:0]   w_nin [DIV_STEPS][3];
    logic [DIV_BITS-1:0]   w_qin [DIV_STEPS][3];
    logic [2:0]            w_rin [DIV_STEPS][3];
    logic [19:0]           w_val [DIV_STEPS][3];
    logic [16:0]           w_qd [DIV_STEPS][3];
    logic signed [52:0]    w_qv [3];
    logic signed [63:0]    w_c1, w_c2;

    // casteljau levels, lane 0 is the trajectory, lane 1 the goal sensitivity
    t_q16                  r_a  [N_CP][LANES][N_CP];
    logic signed [50:0]    r_pr [1:DEG][LANES][DEG];
    t_q16                  r_pb [1:DEG][LANES][DEG];
    t_frac                 r_at [1:DEG];
    t_frac                 r_bt [0:DEG];
    logic signed [34:0]    r_d2 [4][LANES];
    logic signed [32:0]    r_d1 [2][LANES];

    // 1/T scaling
    logic [15:0]           w_inv_hi, w_inv_lo;
    logic signed [37:0]    w_xv [LANES];
    logic signed [39:0]    w_xa [LANES];
    logic signed [54:0]    r_vh [LANES];
    logic signed [54:0]    r_vl [LANES];
    logic signed [56:0]    r_ah [LANES];
    logic signed [56:0]    r_al [LANES];
    logic signed [39:0]    r_acc1 [LANES];
    logic signed [56:0]    r_ah2 [LANES];
    logic signed [56:0]    r_al2 [LANES];
    t_q16                  r_vel [3][LANES];
    t_q16                  r_pp  [4][LANES];
    t_q16                  r_acc_o [LANES];

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration     <= CFG_RESET;
            r_inv_duration <= CFG_RESET;
            r_vld          <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_acc};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DURATION:     r_duration     <= i_cfg_data;
                    REG_INV_DURATION: r_inv_duration <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        w_dd_rnd = ({1'b0, r2_dd} + 65'd32768) >> 16;
        w_u[0] = ((65'(r4_tv) + 65'sd163840) >>> 16) + DIV_BIAS;
        w_u[1] = ((65'(r4_tv) + 65'sd81920) >>> 15) + DIV_BIAS;
        w_u[2] = ((65'(r4_tt) + 65'sd655360) >>> 18) + DIV_BIAS;
        for (int m = 0; m < 3; m++) begin
            w_nin[0][m] = r5_u[m];
            w_qin[0][m] = '0;
            w_rin[0][m] = '0;
            for (int j = 1; j < DIV_STEPS; j++) begin
                w_nin[j][m] = r_dn[j-1][m];
                w_qin[j][m] = r_dq[j-1][m];
                w_rin[j][m] = r_dr[j-1][m];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                w_val[j][m] = {w_rin[j][m], w_nin[j][m][(DIV_STEPS-1-j)*DIG_BITS +: DIG_BITS]};
                w_qd[j][m]  = div5_quo(w_val[j][m]);
            end
            w_qv[m] = $signed({2'b00, r_dq[DIV_STEPS-1][m]}) - QUO_OFS;
        end
        w_c1 = 64'(r_dq0[DIV_STEPS-1]) + 64'(w_qv[0]);
        w_c2 = 64'(r_dq0[DIV_STEPS-1]) + 64'(w_qv[1]) + 64'(w_qv[2]);
        w_inv_hi = r_inv_duration[31:16];
        w_inv_lo = r_inv_duration[15:0];
        for (int l = 0; l < LANES; l++) begin
            w_xv[l] = (38'(r_d1[1][l]) <<< 2) + 38'(r_d1[1][l]);
            w_xa[l] = (40'(r_d2[3][l]) <<< 4) + (40'(r_d2[3][l]) <<< 2);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_t  <= (i_time_frac > Q16_ONE) ? Q16_ONE : i_time_frac;
        r1_q0 <= i_start_pos;
        r1_v0 <= i_start_vel;
        r1_a0 <= i_start_acc;
        r1_g  <= i_goal_pos;

        r2_tv <= $signed({1'b0, r_duration}) * r1_v0;
        r2_dd <= r_duration * r_duration;
        r2_t  <= r1_t;
        r2_q0 <= r1_q0;
        r2_a0 <= r1_a0;
        r2_g  <= r1_g;

        r3_tsq <= (|w_dd_rnd[64:32]) ? '1 : w_dd_rnd[31:0];
        r3_tv  <= r2_tv;
        r3_t   <= r2_t;
        r3_q0  <= r2_q0;
        r3_a0  <= r2_a0;
        r3_g   <= r2_g;

        r4_tt <= $signed({1'b0, r3_tsq}) * r3_a0;
        r4_tv <= r3_tv;
        r4_t  <= r3_t;
        r4_q0 <= r3_q0;
        r4_g  <= r3_g;

        for (int m = 0; m < 3; m++) begin
            r5_u[m] <= w_u[m][DIV_BITS-1:0];
        end
        r5_t  <= r4_t;
        r5_q0 <= r4_q0;
        r5_g  <= r4_g;

        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int m = 0; m < 3; m++) begin
                r_dn[j][m] <= w_nin[j][m];
                r_dq[j][m] <= {w_qin[j][m][DIV_BITS-DIG_BITS-1:0], w_qd[j][m]};
                r_dr[j][m] <= div5_rem(w_val[j][m], w_qd[j][m]);
            end
        end
        r_dt[0]  <= r5_t;
        r_dq0[0] <= r5_q0;
        r_dg[0]  <= r5_g;
        for (int j = 1; j < DIV_STEPS; j++) begin
            r_dt[j]  <= r_dt[j-1];
            r_dq0[j] <= r_dq0[j-1];
            r_dg[j]  <= r_dg[j-1];
        end

        // control points
        r_a[0][0][0] <= r_dq0[DIV_STEPS-1];
        r_a[0][0][1] <= sat32(w_c1);
        r_a[0][0][2] <= sat32(w_c2);
        for (int i = 3; i < N_CP; i++) begin
            r_a[0][0][i] <= r_dg[DIV_STEPS-1];
            r_a[0][1][i] <= Q16_ONE_S;
            r_a[0][1][i-3] <= '0;
        end
        r_bt[0] <= r_dt[DIV_STEPS-1];

        // casteljau: product stage, then round and add stage
        for (int k = 1; k <= DEG; k++) begin
            r_at[k] <= r_bt[k-1];
            r_bt[k] <= r_at[k];
            for (int l = 0; l < LANES; l++) begin
                for (int i = 0; i < DEG; i++) begin
                    if (i < N_CP - k) begin
                        r_pr[k][l][i] <= (33'(r_a[k-1][l][i+1]) - 33'(r_a[k-1][l][i]))
                                         * $signed({1'b0, r_bt[k-1]});
                        r_pb[k][l][i] <= r_a[k-1][l][i];
                        r_a[k][l][i]  <= 32'(add_rnd16(64'(r_pb[k][l][i]),
                                                       64'(r_pr[k][l][i])));
                    end
                end
            end
        end

        for (int l = 0; l < LANES; l++) begin
            r_d2[0][l] <= 35'(r_a[3][l][0]) - (35'(r_a[3][l][1]) <<< 1) + 35'(r_a[3][l][2]);
            for (int s = 1; s < 4; s++) begin
                r_d2[s][l] <= r_d2[s-1][l];
            end
            r_d1[0][l] <= 33'(r_a[4][l][1]) - 33'(r_a[4][l][0]);
            r_d1[1][l] <= r_d1[0][l];

            r_vh[l]  <= w_xv[l] * $signed({1'b0, w_inv_hi});
            r_vl[l]  <= w_xv[l] * $signed({1'b0, w_inv_lo});
            r_ah[l]  <= w_xa[l] * $signed({1'b0, w_inv_hi});
            r_al[l]  <= w_xa[l] * $signed({1'b0, w_inv_lo});
            r_pp[0][l] <= r_a[DEG][l][0];

            r_vel[0][l] <= sat32(add_rnd16(64'(r_vh[l]), 64'(r_vl[l])));
            r_acc1[l]   <= sat40(add_rnd16(64'(r_ah[l]), 64'(r_al[l])));

            r_ah2[l] <= r_acc1[l] * $signed({1'b0, w_inv_hi});
            r_al2[l] <= r_acc1[l] * $signed({1'b0, w_inv_lo});

            r_acc_o[l] <= sat32(add_rnd16(64'(r_ah2[l]), 64'(r_al2[l])));
            for (int s = 1; s < 3; s++) begin
                r_vel[s][l] <= r_vel[s-1][l];
            end
            for (int s = 1; s < 4; s++) begin
                r_pp[s][l] <= r_pp[s-1][l];
            end
        end
    end

    assign o_done     = r_vld[PIPE_LAT-1];
    assign o_pos      = r_pp[3][0];
    assign o_vel      = r_vel[2][0];
    assign o_acc      = r_acc_o[0];
    assign o_pos_sens = r_pp[3][1][16:0];
    assign o_vel_sens = r_vel[2][1];
    assign o_acc_sens = r_acc_o[1];

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_done)
        else $error("accepted sample gave no result");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without accepted sample");

    a_sens_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pos_sens <= Q16_ONE))
        else $error("position sensitivity above one");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the quintic bezier joint evaluator: directed corner
// samples and random trajectories under several duration settings, each
// result compared field by field with a predicted value
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qbje_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = PIPE_LAT + 10;

    typedef struct {
        logic [31:0] pos, vel, acc;
        logic [16:0] pos_sens;
        logic [31:0] vel_sens, acc_sens;
    } t_traj;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_reg_idx    i_cfg_idx = REG_DURATION;
    logic [31:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    t_frac       i_time_frac = '0;
    t_q16        i_start_pos = '0, i_start_vel = '0, i_start_acc = '0, i_goal_pos = '0;
    logic        o_done;
    t_q16        o_pos, o_vel, o_acc, o_vel_sens, o_acc_sens;
    t_frac       o_pos_sens;

    quintic_bezier_joint_eval u_dut (.*);

    initial forever #2 i_clk = ~i_clk;

    longint unsigned cur_dur = 65536, cur_inv = 65536;
    t_traj traj_q[$];
    int    n_err = 0;
    int    idle_cycles = 0;
    bit    quiet = 0;

    function automatic longint fdiv(longint x, longint d);
        longint q = x / d;
        if (x % d < 0) q -= 1;
        return q;
    endfunction

    function automatic longint rnd16(longint x);
        return fdiv(x + 32768, 65536);
    endfunction

    function automatic longint clampb(longint x, int bits);
        longint hi = (64'sd1 <<< (bits - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic longint inv_scale(longint x, longint unsigned inv);
        return x * longint'(inv >> 16) + rnd16(x * longint'(inv & 16'hffff));
    endfunction

    task automatic casteljau(input longint cp[6], input longint t,
                             output longint p, output longint v, output longint a);
        longint w[6];
        longint d1 = 0, d2 = 0;
        w = cp;
        for (int n = 5; n >= 1; n--) begin
            for (int i = 0; i < n; i++) w[i] = w[i] + rnd16((w[i+1] - w[i]) * t);
            if (n == 3) d2 = w[0] - 2 * w[1] + w[2];
            if (n == 2) d1 = w[1] - w[0];
        end
        p = clampb(w[0], 32);
        v = clampb(inv_scale(5 * d1, cur_inv), 32);
        a = clampb(inv_scale(clampb(inv_scale(20 * d2, cur_inv), 40), cur_inv), 32);
    endtask

    task automatic predict_traj(input t_frac tf, input t_q16 q0, input t_q16 v0,
                                input t_q16 a0, input t_q16 g);
        longint t = tf;
        longint tv, tt, cp[6], sp[6], p, v, a, ps, vs, as;
        longint unsigned tsq;
        t_traj r;
        if (t > 65536) t = 65536;
        tv  = longint'(cur_dur) * longint'(v0);
        tsq = (cur_dur * cur_dur + 32768) >> 16;
        if (tsq > 64'hffffffff) tsq = 64'hffffffff;
        tt = longint'(tsq) * longint'(a0);
        cp[0] = q0;
        cp[1] = clampb(q0 + fdiv(tv + 163840, 327680), 32);
        cp[2] = clampb(q0 + fdiv(tv + 81920, 163840) + fdiv(tt + 655360, 1310720), 32);
        for (int i = 0; i < 6; i++) begin
            if (i >= 3) cp[i] = g;
            sp[i] = (i >= 3) ? 65536 : 0;
        end
        casteljau(cp, t, p, v, a);
        casteljau(sp, t, ps, vs, as);
        r.pos = p[31:0]; r.vel = v[31:0]; r.acc = a[31:0];
        r.pos_sens = ps[16:0]; r.vel_sens = vs[31:0]; r.acc_sens = as[31:0];
        traj_q.push_back(r);
    endtask

    task automatic idle_gap();
        while (!quiet && $urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input t_frac tf, input t_q16 q0, input t_q16 v0,
                               input t_q16 a0, input t_q16 g);
        idle_gap();
        start       <= 1'b1;
        i_time_frac <= tf;
        i_start_pos <= q0; i_start_vel <= v0; i_start_acc <= a0; i_goal_pos <= g;
        do @(posedge i_clk); while (busy);
        predict_traj(tf, q0, v0, a0, g);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (traj_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        wait_drain();
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_DURATION) cur_dur = val; else cur_inv = val;
    endtask

    function automatic t_q16 rand_q16();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return t_q16'($urandom_range(655360)) - 32'sd327680;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_frac rand_frac();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return Q16_ONE;
            2: return 17'd65537 + 17'($urandom_range(65534));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic test_corners();
        t_frac fr[5] = '{17'd0, 17'd1, 17'd32768, Q16_ONE, 17'h1ffff};
        foreach (fr[i]) send_sample(fr[i], 32'sd65536, 32'sd131072, -32'sd65536, 32'sd327680);
        send_sample(17'd30000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_sample(17'd30000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_sample(17'd50000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        send_sample(17'd12345, '0, '0, '0, '0);
        send_sample(17'h15555, 32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_sample(rand_frac(), rand_q16(), rand_q16(),
                                                rand_q16(), rand_q16());
    endtask

    task automatic test_duration_sweep();
        logic [31:0] durs[5] = '{32'd0, 32'd1, 32'd16777216, 32'hffffffff, 32'd131072};
        logic [31:0] invs[5] = '{32'd0, 32'hffffffff, 32'd256, 32'd1, 32'd32768};
        for (int k = 0; k < 5; k++) begin
            write_reg(REG_DURATION, durs[k]);
            write_reg(REG_INV_DURATION, invs[k]);
            send_sample(17'd20000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
            send_sample(Q16_ONE, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
            test_random(150);
        end
        write_reg(REG_DURATION, $urandom);
        write_reg(REG_INV_DURATION, $urandom);
        quiet = 1;
        test_random(200);
        quiet = 0;
        test_random(100);
    endtask

    always @(posedge i_clk) begin
        t_traj e;
        if (i_rst_n && o_done) begin
            if (traj_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_err++;
            end else begin
                e = traj_q.pop_front();
                if (o_pos !== e.pos) begin
                    $error("pos exp %h got %h", e.pos, o_pos); n_err++;
                end
                if (o_vel !== e.vel) begin
                    $error("vel exp %h got %h", e.vel, o_vel); n_err++;
                end
                if (o_acc !== e.acc) begin
                    $error("acc exp %h got %h", e.acc, o_acc); n_err++;
                end
                if (o_pos_sens !== e.pos_sens) begin
                    $error("pos_sens exp %h got %h", e.pos_sens, o_pos_sens); n_err++;
                end
                if (o_vel_sens !== e.vel_sens) begin
                    $error("vel_sens exp %h got %h", e.vel_sens, o_vel_sens); n_err++;
                end
                if (o_acc_sens !== e.acc_sens) begin
                    $error("acc_sens exp %h got %h", e.acc_sens, o_acc_sens); n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random(200);
        test_duration_sweep();
        wait_drain();
        if (n_err == 0 && traj_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
